@@ src/udcs_pkg.sv @@
package udcs_pkg;

   localparam int ByteWidth = 8;
   localparam int CsrIndexWidth = 2;

   localparam logic REQ_DATA = 1'b0;
   localparam logic REQ_END  = 1'b1;

   localparam logic [CsrIndexWidth-1:0] CSR_MATCH_CLASS    = 2'd0;
   localparam logic [CsrIndexWidth-1:0] CSR_MATCH_SUBCLASS = 2'd1;
   localparam logic [CsrIndexWidth-1:0] CSR_MATCH_PROTOCOL = 2'd2;

   localparam logic [ByteWidth-1:0] MATCH_CLASS_RESET    = 8'hFF;
   localparam logic [ByteWidth-1:0] MATCH_SUBCLASS_RESET = 8'h42;
   localparam logic [ByteWidth-1:0] MATCH_PROTOCOL_RESET = 8'h01;

   localparam logic [ByteWidth-1:0] DESC_CONFIGURATION = 8'd2;
   localparam logic [ByteWidth-1:0] DESC_INTERFACE     = 8'd4;
   localparam logic [ByteWidth-1:0] DESC_ENDPOINT      = 8'd5;
   localparam logic [ByteWidth-1:0] MIN_DESC_LENGTH    = 8'd2;

   localparam logic [1:0] XFER_BULK = 2'b10;
   localparam int EpDirBit = 7;

   localparam logic [1:0] CAUSE_BOTH_FOUND = 2'd0;
   localparam logic [1:0] CAUSE_END        = 2'd1;
   localparam logic [1:0] CAUSE_SHORT      = 2'd2;

   localparam logic [1:0] EV_DESC  = 2'd0;
   localparam logic [1:0] EV_SHORT = 2'd1;
   localparam logic [1:0] EV_END   = 2'd2;

   localparam int QueueDepth = 2;
   localparam int QueuePtrWidth = $clog2(QueueDepth);
   localparam int QueueCountWidth = $clog2(QueueDepth + 1);

   typedef struct packed {
      logic [1:0]           kind;
      logic [ByteWidth-1:0] desc_type;
      logic                 dir_in;
      logic [1:0]           xfer;
      logic [ByteWidth-1:0] class_byte;
      logic [ByteWidth-1:0] subclass_byte;
      logic [ByteWidth-1:0] protocol_byte;
   } event_type;

   typedef struct packed {
      logic [ByteWidth-1:0] match_class;
      logic [ByteWidth-1:0] match_subclass;
      logic [ByteWidth-1:0] match_protocol;
   } match_cfg_type;

endpackage

@@ src/udcs_if.sv @@
interface udcs_req_if import udcs_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic                 req_type;
   logic [ByteWidth-1:0] data_byte;

   modport source (output valid, output req_type, output data_byte, input ready);
   modport sink (input valid, input req_type, input data_byte, output ready);
endinterface

interface udcs_rsp_if;
   logic       valid;
   logic       ready;
   logic       has_match;
   logic [1:0] finish_cause;
   logic       saw_bulk_in;
   logic       saw_bulk_out;

   modport source (output valid, output has_match, output finish_cause,
                   output saw_bulk_in, output saw_bulk_out, input ready);
   modport sink (input valid, input has_match, input finish_cause,
                 input saw_bulk_in, input saw_bulk_out, output ready);
endinterface

interface udcs_csr_if import udcs_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic [CsrIndexWidth-1:0] index;
   logic [ByteWidth-1:0]     data;

   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

@@ src/udcs_front.sv @@
module udcs_front import udcs_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   udcs_req_if.sink  req,
   output logic      push_valid,
   input  logic      push_ready,
   output event_type push_event
);

   logic [ByteWidth-1:0] offset_ff, offset_in;
   logic [ByteWidth-1:0] length_ff, length_in;
   logic [ByteWidth-1:0] type_ff, type_in;
   logic [ByteWidth-1:0] off2_ff, off2_in;
   logic [ByteWidth-1:0] off3_ff, off3_in;
   logic [ByteWidth-1:0] class_ff, class_in;
   logic [ByteWidth-1:0] subclass_ff, subclass_in;
   logic [ByteWidth-1:0] protocol_ff, protocol_in;
   logic                 accept;
   logic [ByteWidth:0]   next_offset;

   assign req.ready = push_ready;
   assign accept = req.valid & push_ready;
   assign next_offset = {1'b0, offset_ff} + {{ByteWidth{1'b0}}, 1'b1};

   always_comb begin
      offset_in = offset_ff;
      length_in = length_ff;
      type_in = type_ff;
      off2_in = off2_ff;
      off3_in = off3_ff;
      class_in = class_ff;
      subclass_in = subclass_ff;
      protocol_in = protocol_ff;
      push_valid = 1'b0;
      push_event.kind = EV_DESC;
      if (accept) begin
         if (req.req_type == REQ_END) begin
            offset_in = '0;
            length_in = '0;
            type_in = '0;
            off2_in = '0;
            off3_in = '0;
            class_in = '0;
            subclass_in = '0;
            protocol_in = '0;
            push_valid = 1'b1;
            push_event.kind = EV_END;
         end else if (offset_ff == '0) begin
            length_in = req.data_byte;
            if (req.data_byte < MIN_DESC_LENGTH) begin
               push_valid = 1'b1;
               push_event.kind = EV_SHORT;
            end else begin
               offset_in = next_offset[ByteWidth-1:0];
            end
         end else begin
            case (offset_ff)
               8'd1: type_in = req.data_byte;
               8'd2: off2_in = req.data_byte;
               8'd3: off3_in = req.data_byte;
               8'd5: class_in = req.data_byte;
               8'd6: subclass_in = req.data_byte;
               8'd7: protocol_in = req.data_byte;
               default: ;
            endcase
            if (next_offset >= {1'b0, length_ff}) begin
               offset_in = '0;
               push_valid = 1'b1;
               push_event.kind = EV_DESC;
            end else begin
               offset_in = next_offset[ByteWidth-1:0];
            end
         end
      end
      push_event.desc_type = type_in;
      push_event.dir_in = off2_in[EpDirBit];
      push_event.xfer = off3_in[1:0];
      push_event.class_byte = class_in;
      push_event.subclass_byte = subclass_in;
      push_event.protocol_byte = protocol_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         offset_ff <= '0;
         length_ff <= '0;
         type_ff <= '0;
         off2_ff <= '0;
         off3_ff <= '0;
         class_ff <= '0;
         subclass_ff <= '0;
         protocol_ff <= '0;
      end else begin
         offset_ff <= offset_in;
         length_ff <= length_in;
         type_ff <= type_in;
         off2_ff <= off2_in;
         off3_ff <= off3_in;
         class_ff <= class_in;
         subclass_ff <= subclass_in;
         protocol_ff <= protocol_in;
      end
   end

endmodule

@@ src/udcs_queue.sv @@
module udcs_queue import udcs_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      push_valid,
   output logic      push_ready,
   input  event_type push_event,
   output logic      pop_valid,
   input  logic      pop_ready,
   output event_type pop_event
);

   event_type                  entry_ff [QueueDepth];
   logic [QueuePtrWidth-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QueuePtrWidth-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QueueCountWidth-1:0] count_ff, count_in;
   logic                       do_push;
   logic                       do_pop;

   assign pop_valid = count_ff != '0;
   assign pop_event = entry_ff[rd_ptr_ff];
   assign do_pop = pop_valid & pop_ready;
   assign push_ready = (count_ff != QueueCountWidth'(QueueDepth)) | do_pop;
   assign do_push = push_valid & push_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QueuePtrWidth'(QueueDepth - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QueuePtrWidth'(QueueDepth - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push & ~do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop & ~do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_event;
      end
   end

endmodule

@@ src/udcs_back.sv @@
module udcs_back import udcs_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  match_cfg_type cfg,
   input  logic          pop_valid,
   output logic          pop_ready,
   input  event_type     pop_event,
   udcs_rsp_if.source    rsp
);

   logic       inside_ff, inside_in;
   logic       bulk_in_ff, bulk_in_in;
   logic       bulk_out_ff, bulk_out_in;
   logic       verdict_ff, verdict_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       match_ff, match_in;
   logic [1:0] cause_ff, cause_in;
   logic       saw_in_ff, saw_in_in;
   logic       saw_out_ff, saw_out_in;
   logic       process;
   logic       emit;

   assign pop_ready = ~rsp_valid_ff | rsp.ready;
   assign process = pop_valid & pop_ready;

   always_comb begin
      inside_in = inside_ff;
      bulk_in_in = bulk_in_ff;
      bulk_out_in = bulk_out_ff;
      verdict_in = verdict_ff;
      emit = 1'b0;
      match_in = match_ff;
      cause_in = cause_ff;
      if (process) begin
         if (pop_event.kind == EV_END) begin
            if (!verdict_ff) begin
               emit = 1'b1;
               match_in = bulk_in_ff & bulk_out_ff & inside_ff;
               cause_in = CAUSE_END;
            end
         end else if (!verdict_ff) begin
            case (pop_event.kind)
               EV_SHORT: begin
                  emit = 1'b1;
                  match_in = 1'b0;
                  cause_in = CAUSE_SHORT;
               end
               EV_DESC: begin
                  if (pop_event.desc_type == DESC_CONFIGURATION) begin
                     inside_in = 1'b0;
                  end else if (pop_event.desc_type == DESC_INTERFACE) begin
                     inside_in = (pop_event.class_byte == cfg.match_class) &&
                                 (pop_event.subclass_byte == cfg.match_subclass) &&
                                 (pop_event.protocol_byte == cfg.match_protocol);
                  end else if (pop_event.desc_type == DESC_ENDPOINT && inside_ff) begin
                     if (pop_event.xfer == XFER_BULK) begin
                        if (pop_event.dir_in) begin
                           bulk_in_in = 1'b1;
                        end else begin
                           bulk_out_in = 1'b1;
                        end
                     end
                     if (bulk_in_in && bulk_out_in) begin
                        emit = 1'b1;
                        match_in = inside_ff;
                        cause_in = CAUSE_BOTH_FOUND;
                     end
                  end
               end
               default: ;
            endcase
         end
      end
      saw_in_in = emit ? bulk_in_in : saw_in_ff;
      saw_out_in = emit ? bulk_out_in : saw_out_ff;
      if (emit) begin
         verdict_in = 1'b1;
      end
      if (process && pop_event.kind == EV_END) begin
         inside_in = 1'b0;
         bulk_in_in = 1'b0;
         bulk_out_in = 1'b0;
         verdict_in = 1'b0;
      end
      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         inside_ff <= 1'b0;
         bulk_in_ff <= 1'b0;
         bulk_out_ff <= 1'b0;
         verdict_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         inside_ff <= inside_in;
         bulk_in_ff <= bulk_in_in;
         bulk_out_ff <= bulk_out_in;
         verdict_ff <= verdict_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      match_ff <= match_in;
      cause_ff <= cause_in;
      saw_in_ff <= saw_in_in;
      saw_out_ff <= saw_out_in;
   end

   assign rsp.valid = rsp_valid_ff;
   assign rsp.has_match = match_ff;
   assign rsp.finish_cause = cause_ff;
   assign rsp.saw_bulk_in = saw_in_ff;
   assign rsp.saw_bulk_out = saw_out_ff;

`ifndef SYNTH
   // A verdict for both endpoints always carries both flags.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && cause_ff == CAUSE_BOTH_FOUND |-> saw_in_ff && saw_out_ff)
      else $error("both-found verdict without both endpoints");

   // A short-length verdict never reports a match.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && cause_ff == CAUSE_SHORT |-> !match_ff)
      else $error("short-length verdict reports a match");

   // A new verdict is only raised while no verdict has been given in this stream.
   assert property (@(posedge clock) disable iff (reset)
      emit |-> !verdict_ff)
      else $error("second verdict in one stream");

   // Once given, the verdict flag stays set until an end of stream is processed.
   assert property (@(posedge clock) disable iff (reset)
      verdict_ff && !(process && pop_event.kind == EV_END) |=> verdict_ff)
      else $error("verdict flag dropped within a stream");
`endif

endmodule

@@ src/usb_descriptor_class_scanner_core.sv @@
// Scans a USB descriptor stream, one byte per request transaction, and gives one verdict
// per stream on the response channel: early when a bulk IN and a bulk OUT endpoint have
// both been found in an interface whose class, subclass and protocol match the three
// configuration registers, early when a length byte below two is seen, and otherwise at
// the end-of-stream transaction, which also returns the scanner to its reset state. A
// byte is accepted in every cycle while the two-entry event queue has room, so the
// sustained rate is one transaction per cycle; a verdict reaches the response channel
// through the queue entry and then the verdict register, and the framing stage in front
// of the queue adds no register. Register writes are always accepted at once and must
// only be made while the scanner is idle.
module usb_descriptor_class_scanner_core import udcs_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   udcs_req_if.sink   req_port,
   udcs_rsp_if.source rsp_port,
   udcs_csr_if.sink   csr_port
);

   match_cfg_type cfg_ff, cfg_in;
   logic          push_valid;
   logic          push_ready;
   event_type     push_event;
   logic          pop_valid;
   logic          pop_ready;
   event_type     pop_event;

   assign csr_port.ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_port.valid) begin
         case (csr_port.index)
            CSR_MATCH_CLASS:    cfg_in.match_class = csr_port.data;
            CSR_MATCH_SUBCLASS: cfg_in.match_subclass = csr_port.data;
            CSR_MATCH_PROTOCOL: cfg_in.match_protocol = csr_port.data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.match_class <= MATCH_CLASS_RESET;
         cfg_ff.match_subclass <= MATCH_SUBCLASS_RESET;
         cfg_ff.match_protocol <= MATCH_PROTOCOL_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   udcs_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req        (req_port),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_event (push_event)
   );

   udcs_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_event (push_event),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_event  (pop_event)
   );

   udcs_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_event (pop_event),
      .rsp       (rsp_port)
   );

endmodule

@@ verif/usb_descriptor_class_scanner_core_tb.sv @@
module usb_descriptor_class_scanner_core_tb;
   import udcs_pkg::*;

   localparam logic [CsrIndexWidth-1:0] CSR_UNUSED = 2'd3;
   localparam int ItemTarget = 1350;
   localparam int SegmentCount = 6;
   localparam int HoldCycles = 400;
   localparam int SettleCycles = 10;

   typedef struct packed {
      logic       has_match;
      logic [1:0] finish_cause;
      logic       saw_bulk_in;
      logic       saw_bulk_out;
   } verdict_type;

   class verdict_scoreboard;
      logic [ByteWidth-1:0] match_class = MATCH_CLASS_RESET;
      logic [ByteWidth-1:0] match_subclass = MATCH_SUBCLASS_RESET;
      logic [ByteWidth-1:0] match_protocol = MATCH_PROTOCOL_RESET;
      logic [ByteWidth-1:0] offset, length, dtype, ep_address, ep_attributes;
      logic [ByteWidth-1:0] if_class, if_subclass, if_protocol;
      bit in_match, bulk_in, bulk_out, verdict_done;
      verdict_type expected_verdicts[$];
      int errors;

      function void clear_scan();
         offset = 0;
         length = 0;
         dtype = 0;
         ep_address = 0;
         ep_attributes = 0;
         if_class = 0;
         if_subclass = 0;
         if_protocol = 0;
         in_match = 0;
         bulk_in = 0;
         bulk_out = 0;
         verdict_done = 0;
      endfunction

      function void write_register(logic [CsrIndexWidth-1:0] index, logic [ByteWidth-1:0] value);
         case (index)
            CSR_MATCH_CLASS: match_class = value;
            CSR_MATCH_SUBCLASS: match_subclass = value;
            CSR_MATCH_PROTOCOL: match_protocol = value;
            default: ;
         endcase
      endfunction

      function void give_verdict(bit matched, logic [1:0] cause);
         verdict_type v;
         v.has_match = matched;
         v.finish_cause = cause;
         v.saw_bulk_in = bulk_in;
         v.saw_bulk_out = bulk_out;
         expected_verdicts.push_back(v);
         verdict_done = 1;
      endfunction

      // Returns whether a bulk endpoint pair is complete after the descriptor that just ended.
      function bit close_descriptor();
         if (dtype == DESC_CONFIGURATION) begin
            in_match = 0;
         end else if (dtype == DESC_INTERFACE) begin
            in_match = if_class == match_class && if_subclass == match_subclass &&
                       if_protocol == match_protocol;
         end else if (dtype == DESC_ENDPOINT && in_match) begin
            if (ep_attributes[1:0] == XFER_BULK) begin
               if (ep_address[EpDirBit]) bulk_in = 1;
               else bulk_out = 1;
            end
            return bulk_in && bulk_out;
         end
         return 0;
      endfunction

      function void note_request(logic kind, logic [ByteWidth-1:0] value);
         if (kind == REQ_END) begin
            if (!verdict_done) give_verdict(bulk_in && bulk_out && in_match, CAUSE_END);
            clear_scan();
            return;
         end
         if (verdict_done) return;
         if (offset == 0) begin
            length = value;
            if (value < MIN_DESC_LENGTH) give_verdict(0, CAUSE_SHORT);
            else offset = 1;
            return;
         end
         case (offset)
            8'd1: dtype = value;
            8'd2: ep_address = value;
            8'd3: ep_attributes = value;
            8'd5: if_class = value;
            8'd6: if_subclass = value;
            8'd7: if_protocol = value;
            default: ;
         endcase
         if ({1'b0, offset} + 9'd1 >= {1'b0, length}) begin
            offset = 0;
            if (close_descriptor()) give_verdict(in_match, CAUSE_BOTH_FOUND);
         end else begin
            offset = offset + 8'd1;
         end
      endfunction

      function void check_verdict(verdict_type got);
         verdict_type want;
         if (expected_verdicts.size() == 0) begin
            $display("%0t: unexpected verdict, expected none, got %b", $time, got);
            errors++;
            return;
         end
         want = expected_verdicts.pop_front();
         if (got.has_match !== want.has_match) begin
            $display("%0t: has_match expected %b, got %b", $time, want.has_match, got.has_match);
            errors++;
         end
         if (got.finish_cause !== want.finish_cause) begin
            $display("%0t: finish_cause expected %0d, got %0d", $time, want.finish_cause,
                     got.finish_cause);
            errors++;
         end
         if (got.saw_bulk_in !== want.saw_bulk_in) begin
            $display("%0t: saw_bulk_in expected %b, got %b", $time, want.saw_bulk_in,
                     got.saw_bulk_in);
            errors++;
         end
         if (got.saw_bulk_out !== want.saw_bulk_out) begin
            $display("%0t: saw_bulk_out expected %b, got %b", $time, want.saw_bulk_out,
                     got.saw_bulk_out);
            errors++;
         end
      endfunction
   endclass

   logic clock;
   logic reset;

   udcs_req_if req_if ();
   udcs_rsp_if rsp_if ();
   udcs_csr_if csr_if ();

   verdict_scoreboard board = new;
   int items_sent;
   int send_idle_pct = 11;
   int recv_stall_pct = 83;
   bit hold_request;
   logic [ByteWidth-1:0] cur_class = MATCH_CLASS_RESET;
   logic [ByteWidth-1:0] cur_subclass = MATCH_SUBCLASS_RESET;
   logic [ByteWidth-1:0] cur_protocol = MATCH_PROTOCOL_RESET;

   usb_descriptor_class_scanner_core u_top (
      .clock    (clock),
      .reset    (reset),
      .req_port (req_if),
      .rsp_port (rsp_if),
      .csr_port (csr_if)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      #1600000;
      $display("FAILED: results differ");
      $finish;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (csr_if.valid && csr_if.ready) board.write_register(csr_if.index, csr_if.data);
         if (req_if.valid && req_if.ready) board.note_request(req_if.req_type, req_if.data_byte);
         if (rsp_if.valid && rsp_if.ready) begin
            board.check_verdict({rsp_if.has_match, rsp_if.finish_cause, rsp_if.saw_bulk_in,
                                 rsp_if.saw_bulk_out});
         end
      end
   end

   // The long hold-off lets the sender keep offering transactions until the block backs up.
   initial begin
      rsp_if.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_request) begin
            rsp_if.ready <= 1'b0;
            repeat (HoldCycles) @(posedge clock);
            hold_request = 1'b0;
         end
         rsp_if.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   function automatic logic [ByteWidth-1:0] rand_byte();
      return ByteWidth'($urandom);
   endfunction

   task automatic send_item(input logic kind, input logic [ByteWidth-1:0] value);
      while ($urandom_range(99) < send_idle_pct) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.req_type <= kind;
      req_if.data_byte <= value;
      do @(posedge clock); while (!req_if.ready);
      items_sent++;
   endtask

   task automatic send_end();
      send_item(REQ_END, rand_byte());
   endtask

   task automatic send_desc(input int len, input logic [ByteWidth-1:0] dtype, b2, b3, cls, sub,
                            pro, input int stop);
      logic [ByteWidth-1:0] value;
      send_item(REQ_DATA, len[7:0]);
      for (int i = 1; i < len && i < stop; i++) begin
         case (i)
            1: value = dtype;
            2: value = b2;
            3: value = b3;
            5: value = cls;
            6: value = sub;
            7: value = pro;
            default: value = rand_byte();
         endcase
         send_item(REQ_DATA, value);
      end
   endtask

   task automatic send_stream();
      int pick, len;
      logic [ByteWidth-1:0] c, s, p, attr;
      logic [31:0] r;
      if ($urandom_range(9) == 0) begin
         repeat ($urandom_range(1, 12)) begin
            r = $urandom;
            send_item(r[8], r[7:0]);
         end
         send_end();
         return;
      end
      send_desc(9, DESC_CONFIGURATION, rand_byte(), rand_byte(), rand_byte(), rand_byte(),
                rand_byte(), 9);
      repeat ($urandom_range(1, 3)) begin
         c = cur_class;
         s = cur_subclass;
         p = cur_protocol;
         pick = $urandom_range(9);
         if (pick == 0) c = rand_byte();
         else if (pick == 1) s = rand_byte();
         else if (pick == 2) p = rand_byte();
         len = ($urandom_range(19) == 0) ? $urandom_range(2, 7) : 9;
         send_desc(len, DESC_INTERFACE, rand_byte(), rand_byte(), c, s, p, len);
         repeat ($urandom_range(0, 3)) begin
            r = $urandom;
            pick = $urandom_range(15);
            if (pick == 0) begin
               len = $urandom_range(2, 12);
               send_desc(len, r[23:16], r[7:0], r[15:8], rand_byte(), rand_byte(),
                         rand_byte(), len);
            end else if (pick == 1) begin
               send_desc(9, DESC_CONFIGURATION, r[7:0], r[15:8], c, s, p, 9);
            end else begin
               attr = (r[31:30] != 2'd0) ? {r[13:8], XFER_BULK} : r[15:8];
               len = (r[29:28] == 2'd0) ? $urandom_range(4, 9) : 7;
               send_desc(len, DESC_ENDPOINT, r[7:0], attr, rand_byte(), rand_byte(),
                         rand_byte(), len);
            end
         end
      end
      pick = $urandom_range(19);
      if (pick == 0) begin
         send_item(REQ_DATA, ByteWidth'($urandom_range(1)));
      end else if (pick == 1) begin
         len = $urandom_range(13, 255);
         send_desc(len, rand_byte(), rand_byte(), rand_byte(), rand_byte(), rand_byte(),
                   rand_byte(), $urandom_range(1, len));
      end else if (pick == 2) begin
         send_desc(7, DESC_ENDPOINT, rand_byte(), rand_byte(), rand_byte(), rand_byte(),
                   rand_byte(), $urandom_range(1, 6));
      end
      send_end();
   endtask

   task automatic write_csr(input logic [CsrIndexWidth-1:0] index,
                            input logic [ByteWidth-1:0] value);
      csr_if.valid <= 1'b1;
      csr_if.index <= index;
      csr_if.data <= value;
      do @(posedge clock); while (!csr_if.ready);
   endtask

   task automatic configure(input logic [ByteWidth-1:0] c, s, p);
      write_csr(CSR_MATCH_CLASS, c);
      write_csr(CSR_MATCH_SUBCLASS, s);
      write_csr(CSR_MATCH_PROTOCOL, p);
      csr_if.valid <= 1'b0;
      cur_class = c;
      cur_subclass = s;
      cur_protocol = p;
      @(posedge clock);
   endtask

   task automatic drain();
      req_if.valid <= 1'b0;
      @(posedge clock);
      while (board.expected_verdicts.size() != 0) @(posedge clock);
      repeat (SettleCycles) @(posedge clock);
   endtask

   initial begin
      reset <= 1'b1;
      req_if.valid <= 1'b0;
      req_if.req_type <= REQ_DATA;
      req_if.data_byte <= '0;
      csr_if.valid <= 1'b0;
      csr_if.index <= CSR_MATCH_CLASS;
      csr_if.data <= '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_item(REQ_DATA, 8'h01);
      send_end();
      send_item(REQ_DATA, 8'h00);
      send_end();
      send_end();
      send_desc(8, DESC_INTERFACE, 8'h00, 8'h00, MATCH_CLASS_RESET, MATCH_SUBCLASS_RESET,
                MATCH_PROTOCOL_RESET, 8);
      send_desc(4, DESC_ENDPOINT, 8'h81, 8'h02, 8'h00, 8'h00, 8'h00, 4);
      send_desc(4, DESC_ENDPOINT, 8'h01, 8'h02, 8'h00, 8'h00, 8'h00, 4);
      send_item(REQ_DATA, 8'hFF);
      send_end();
      drain();

      for (int seg = 0; seg < SegmentCount; seg++) begin
         if (seg == 3) write_csr(CSR_UNUSED, rand_byte());
         case (seg)
            1: configure(8'h00, 8'h00, 8'h00);
            2: configure(8'hFF, 8'hFF, 8'hFF);
            4: configure(MATCH_CLASS_RESET, MATCH_SUBCLASS_RESET, MATCH_PROTOCOL_RESET);
            default: configure(rand_byte(), rand_byte(), rand_byte());
         endcase
         if (seg < 2) begin
            send_idle_pct = 11;
            recv_stall_pct = 83;
         end else if (seg < 4) begin
            send_idle_pct = 83;
            recv_stall_pct = 11;
         end else begin
            send_idle_pct = 0;
            recv_stall_pct = 0;
         end
         if (seg == SegmentCount - 1) begin
            hold_request = 1'b1;
            repeat (30) begin
               send_item(REQ_DATA, ByteWidth'($urandom_range(1)));
               send_end();
            end
         end
         while (items_sent < (seg + 1) * ItemTarget / SegmentCount) send_stream();
         drain();
      end

      if (board.errors == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule
